### sv/fpa_pkg.sv
package fpa_pkg;

  localparam int unsigned FracBitsDefault  = 8;
  localparam int unsigned WordWidthDefault = 32;
  localparam int unsigned CmdWidth         = 4;
  localparam int unsigned DataWidth        = 32;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADD = 4'd0,
    CMD_SUB = 4'd1,
    CMD_MUL = 4'd2,
    CMD_DIV = 4'd3,
    CMD_LT  = 4'd4,
    CMD_LE  = 4'd5,
    CMD_GT  = 4'd6,
    CMD_GE  = 4'd7,
    CMD_EQ  = 4'd8,
    CMD_NE  = 4'd9,
    CMD_MIN = 4'd10,
    CMD_MAX = 4'd11,
    CMD_INC = 4'd12,
    CMD_DEC = 4'd13
  } cmd_e;

endpackage

### sv/fpa_div_cell.sv
// one restoring step of an unsigned divide, one quotient bit per cell
module fpa_div_cell #(
  parameter int unsigned NumWidth = 40,
  parameter int unsigned DenWidth = 32
) (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [DenWidth:0]   rem_i,
  input  logic [NumWidth-1:0] num_i,
  input  logic [DenWidth-1:0] den_i,
  output logic [DenWidth:0]   rem_o,
  output logic [NumWidth-1:0] num_o,
  output logic [DenWidth-1:0] den_o
);

  logic [DenWidth+1:0] trial;
  logic [DenWidth+1:0] shifted;
  logic [DenWidth:0]   rem_d, rem_q;
  logic [NumWidth-1:0] num_d, num_q;
  logic [DenWidth-1:0] den_q;

  always_comb begin
    shifted = {rem_i, num_i[NumWidth-1]};
    trial   = shifted - {2'b00, den_i};
    if (!trial[DenWidth+1]) begin
      rem_d = trial[DenWidth:0];
      num_d = {num_i[NumWidth-2:0], 1'b1};
    end else begin
      rem_d = shifted[DenWidth:0];
      num_d = {num_i[NumWidth-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      num_q <= num_d;
      den_q <= den_i;
    end
  end

  assign rem_o = rem_q;
  assign num_o = num_q;
  assign den_o = den_q;

endmodule

### sv/fpa_side_cell.sv
// carries the result of non-divide operations beside the divider cells
module fpa_side_cell #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [Width-1:0] data_i,
  output logic [Width-1:0] data_o
);

  logic [Width-1:0] data_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

### sv/fixed_point_alu_q24_8.sv
// Signed fixed-point ALU: add, sub, mul, div, six compares, min, max, inc, dec on raw
// WordWidth-bit words with FracBits fraction bits. A request is taken every cycle while
// stall_i is low; each result is registered in stage 0, in the divider and in the output
// register. The divider is a chain of one-bit restoring cells that every operation passes
// through. Division by zero returns zero with div_by_zero_o set.
module fixed_point_alu_q24_8 #(
  parameter int unsigned FracBits  = fpa_pkg::FracBitsDefault,
  parameter int unsigned WordWidth = fpa_pkg::WordWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          stall_o,
  input  logic [fpa_pkg::CmdWidth-1:0]  cmd_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_b_i,
  output logic                          valid_o,
  input  logic                          stall_i,
  output logic signed [fpa_pkg::DataWidth-1:0] result_o,
  output logic                          compare_true_o,
  output logic                          div_by_zero_o
);
  import fpa_pkg::*;

  localparam int unsigned NumW   = WordWidth + FracBits;
  localparam int unsigned Depth  = NumW + 2;
  localparam int unsigned SideW  = WordWidth + 4;

  logic en;
  assign en      = !(valid_o && stall_i);
  assign stall_o = !en;

  logic [Depth-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[Depth-2:0], valid_i};
    end
  end
  assign valid_o = vld_q[Depth-1];

  // stage 0: operand prep and simple ops
  logic signed [WordWidth-1:0] a, b;
  logic signed [WordWidth-1:0] simple;
  logic cmp, isdiv, dz;
  logic [NumW-1:0] mag_a;
  logic [WordWidth-1:0] mag_b;
  assign a = operand_a_i[WordWidth-1:0];
  assign b = operand_b_i[WordWidth-1:0];

  logic signed [2*WordWidth-1:0] prod_q;
  logic ismul_q;
  logic [SideW-1:0] s0_q;
  logic [NumW-1:0] num0_q;
  logic [WordWidth-1:0] den0_q;

  always_comb begin
    simple = '0;
    cmp    = 1'b0;
    unique case (cmd_i)
      CMD_ADD: simple = a + b;
      CMD_SUB: simple = a - b;
      CMD_LT:  cmp = a < b;
      CMD_LE:  cmp = a <= b;
      CMD_GT:  cmp = a > b;
      CMD_GE:  cmp = a >= b;
      CMD_EQ:  cmp = a == b;
      CMD_NE:  cmp = a != b;
      CMD_MIN: simple = (a > b) ? b : a;
      CMD_MAX: simple = (a > b) ? a : b;
      CMD_INC: simple = a + WordWidth'(1);
      CMD_DEC: simple = a - WordWidth'(1);
      default: simple = '0;
    endcase
    isdiv = cmd_i == CMD_DIV;
    dz    = isdiv && (b == '0);
    mag_a = a[WordWidth-1] ? NumW'(-{{FracBits{a[WordWidth-1]}}, a}) << FracBits
                           : NumW'({{FracBits{1'b0}}, a}) << FracBits;
    mag_b = b[WordWidth-1] ? -b : b;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q  <= (2*WordWidth)'(a) * (2*WordWidth)'(b);
      ismul_q <= cmd_i == CMD_MUL;
      // side: {neg, isdiv, dz, cmp, simple}
      s0_q    <= {(a[WordWidth-1] ^ b[WordWidth-1]) & !dz, isdiv & !dz, dz, cmp,
                  simple};
      num0_q  <= mag_a;
      den0_q  <= mag_b;
    end
  end

  // stage 1: finish multiply, enter divider chain
  logic [SideW-1:0] s1;
  logic signed [2*WordWidth-1:0] prod_sh;
  assign prod_sh = prod_q >>> FracBits;
  assign s1 = ismul_q ? {s0_q[SideW-1:WordWidth], prod_sh[WordWidth-1:0]} : s0_q;

  logic [WordWidth:0]   rem  [NumW+1];
  logic [NumW-1:0]      num  [NumW+1];
  logic [WordWidth-1:0] den  [NumW+1];
  logic [SideW-1:0]     side [NumW+1];
  assign rem[0]  = '0;
  assign num[0]  = num0_q;
  assign den[0]  = den0_q;
  assign side[0] = s1;

  for (genvar i = 0; i < NumW; i++) begin : g_cell
    fpa_div_cell #(.NumWidth(NumW), .DenWidth(WordWidth)) u_div (
      .clk_i, .en_i(en),
      .rem_i(rem[i]), .num_i(num[i]), .den_i(den[i]),
      .rem_o(rem[i+1]), .num_o(num[i+1]), .den_o(den[i+1])
    );
    fpa_side_cell #(.Width(SideW)) u_side (
      .clk_i, .en_i(en), .data_i(side[i]), .data_o(side[i+1])
    );
  end

  // output register
  logic [WordWidth-1:0] quo;
  logic [SideW-1:0] so;
  assign so  = side[NumW];
  assign quo = so[SideW-1] ? -num[NumW][WordWidth-1:0] : num[NumW][WordWidth-1:0];

  logic [WordWidth-1:0] res_q;
  logic cmp_q, dz_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= so[WordWidth+2] ? quo : (so[WordWidth+1] ? '0 : so[WordWidth-1:0]);
      cmp_q <= so[WordWidth];
      dz_q  <= so[WordWidth+1];
    end
  end

  assign result_o       = DataWidth'(signed'(res_q));
  assign compare_true_o = cmp_q;
  assign div_by_zero_o  = dz_q;

endmodule

### verif/fixed_point_alu_q24_8_checker.sv
module fixed_point_alu_q24_8_checker (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 req_valid_i,
  input  logic                                 req_stall_i,
  input  logic [fpa_pkg::CmdWidth-1:0]         cmd_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_a_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] operand_b_i,
  input  logic                                 rsp_valid_i,
  input  logic                                 rsp_stall_i,
  input  logic signed [fpa_pkg::DataWidth-1:0] result_i,
  input  logic                                 compare_true_i,
  input  logic                                 div_by_zero_i,
  output int                                   errors_o,
  output int                                   pending_o
);
  import fpa_pkg::*;

  localparam int Frac = FracBitsDefault;

  typedef struct packed {
    logic signed [31:0] value;
    logic               cmp;
    logic               dz;
  } alu_out_t;

  alu_out_t expected_q[$];

  function automatic alu_out_t alu_compute(logic [3:0] op, logic signed [31:0] a,
                                           logic signed [31:0] b);
    alu_out_t r;
    logic signed [63:0] wa, wb, prod, quo;
    r = '0;
    wa = a;
    wb = b;
    case (op)
      CMD_ADD: r.value = a + b;
      CMD_SUB: r.value = a - b;
      CMD_MUL: begin
        prod = (wa * wb) >>> Frac;
        r.value = prod[31:0];
      end
      CMD_DIV: begin
        if (b == 0) begin
          r.dz = 1'b1;
        end else begin
          quo = (wa <<< Frac) / wb;
          r.value = quo[31:0];
        end
      end
      CMD_LT:  r.cmp = a < b;
      CMD_LE:  r.cmp = a <= b;
      CMD_GT:  r.cmp = a > b;
      CMD_GE:  r.cmp = a >= b;
      CMD_EQ:  r.cmp = a == b;
      CMD_NE:  r.cmp = a != b;
      CMD_MIN: r.value = (a > b) ? b : a;
      CMD_MAX: r.value = (a > b) ? a : b;
      CMD_INC: r.value = a + 32'sd1;
      CMD_DEC: r.value = a - 32'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
  end

  assign pending_o = expected_q.size();

  always @(posedge clk_i) begin
    alu_out_t want;
    if (rst_ni) begin
      if (req_valid_i && !req_stall_i) begin
        expected_q.push_back(alu_compute(cmd_i, operand_a_i, operand_b_i));
      end
      if (rsp_valid_i && !rsp_stall_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", result_i, '0);
        end else begin
          want = expected_q.pop_front();
          if (result_i !== want.value) report_mismatch("result", result_i, want.value);
          if (compare_true_i !== want.cmp) begin
            report_mismatch("compare", {31'b0, compare_true_i}, {31'b0, want.cmp});
          end
          if (div_by_zero_i !== want.dz) begin
            report_mismatch("div_by_zero", {31'b0, div_by_zero_i}, {31'b0, want.dz});
          end
        end
      end
    end
  end
endmodule

### verif/fixed_point_alu_q24_8_tb.sv
module fixed_point_alu_q24_8_tb;
  import fpa_pkg::*;

  localparam int NumRandom = 1630;
  localparam int Latency = WordWidthDefault + FracBitsDefault + 2;

  logic clk, rst_n;
  logic valid_in, stall_out, valid_out, stall_in;
  logic [CmdWidth-1:0] cmd;
  logic signed [DataWidth-1:0] op_a, op_b;
  logic signed [DataWidth-1:0] result;
  logic compare_true, div_by_zero;
  int errors, pending;
  bit quiet_phase, hold_done;

  fixed_point_alu_q24_8 uut (
    .clk_i(clk), .rst_ni(rst_n), .valid_i(valid_in), .stall_o(stall_out),
    .cmd_i(cmd), .operand_a_i(op_a), .operand_b_i(op_b),
    .valid_o(valid_out), .stall_i(stall_in), .result_o(result),
    .compare_true_o(compare_true), .div_by_zero_o(div_by_zero)
  );

  fixed_point_alu_q24_8_checker chk (
    .clk_i(clk), .rst_ni(rst_n), .req_valid_i(valid_in), .req_stall_i(stall_out),
    .cmd_i(cmd), .operand_a_i(op_a), .operand_b_i(op_b),
    .rsp_valid_i(valid_out), .rsp_stall_i(stall_in), .result_i(result),
    .compare_true_i(compare_true), .div_by_zero_i(div_by_zero),
    .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'd0;
      3: return $urandom_range(0, 2047) - 1024;
      4: return {{16{1'b0}}, 16'($urandom)};
      5: return 32'($signed(16'($urandom)));
      default: return $urandom;
    endcase
  endfunction

  // one request: hold until accepted, then optional idle burst
  task automatic send(logic [3:0] c, logic [31:0] a, logic [31:0] b);
    int gap;
    valid_in <= 1'b1;
    cmd <= c;
    op_a <= a;
    op_b <= b;
    do @(posedge clk); while (stall_out);
    @(negedge clk);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      valid_in <= 1'b0;
      cmd <= CmdWidth'($urandom);
      op_a <= $urandom;
      op_b <= $urandom;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
  endtask

  // receiver side stalls, with one long hold-off early on
  initial begin
    int n;
    stall_in = 1'b0;
    @(posedge rst_n);
    repeat (20) @(negedge clk);
    stall_in <= 1'b1;
    repeat (300) @(negedge clk);
    stall_in <= 1'b0;
    hold_done = 1'b1;
    forever begin
      @(negedge clk);
      if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        stall_in <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n) @(negedge clk);
        stall_in <= 1'b0;
      end
    end
  end

  initial begin
    logic [31:0] edge_vals [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'hffff_ffff};
    int k;
    rst_n = 1'b0;
    valid_in = 1'b0;
    cmd = '0;
    op_a = '0;
    op_b = '0;
    quiet_phase = 1'b0;
    hold_done = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    for (int c = 0; c < 16; c++) send(4'(c), edge_vals[c % 4], edge_vals[(c + 1) % 4]);
    send(CMD_DIV, 32'h0000_0100, 32'd0);
    send(CMD_DIV, 32'h8000_0000, 32'hffff_ffff);
    send(CMD_MUL, 32'h8000_0000, 32'h8000_0000);
    send(CMD_MIN, 32'h1234, 32'h1234);
    send(CMD_MAX, 32'h8000_0000, 32'h8000_0000);
    send(CMD_INC, 32'h7fff_ffff, 32'hffff_ffff);
    send(CMD_DEC, 32'h8000_0000, 32'h0);
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 200) quiet_phase = 1'b1;
      k = $urandom_range(0, 19);
      if (k == 0) send(CMD_DIV, pick_operand(), 32'd0);
      else if (k == 1) send(4'(14 + $urandom_range(0, 1)), $urandom, $urandom);
      else if (k == 2) begin
        k = pick_operand();
        send(4'($urandom_range(CMD_LT, CMD_MAX)), k, k);
      end else send(4'($urandom_range(0, 13)), pick_operand(), pick_operand());
    end
    valid_in <= 1'b0;
    wait (hold_done && pending == 0);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end
endmodule

### filelist.f
sv/fpa_pkg.sv
sv/fpa_div_cell.sv
sv/fpa_side_cell.sv
sv/fixed_point_alu_q24_8.sv
verif/fixed_point_alu_q24_8_checker.sv
verif/fixed_point_alu_q24_8_tb.sv
